FILE: sv/csm_pkg.sv
// Shared types and constants for the collinear segment merger.
// No dependencies; used by every module of the block.
package csm_pkg;

  localparam int COORD_W_DEF = 24;

  localparam int JT_W = 10;
  localparam int CT_W = 16;
  localparam logic [CT_W-1:0] CT_RESET = 16'd66;

  // digit width of the shared serial multiplier
  localparam int DIGIT_W = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_JOIN_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLL_TOL = 1'b1;

  // products run in this order on the shared multiplier
  typedef enum logic [3:0] {
    OP_D0X2,
    OP_D0Y2,
    OP_D1X2,
    OP_D1Y2,
    OP_P,
    OP_Q,
    OP_C2,
    OP_TOL2,
    OP_R1,
    OP_RHS
  } mul_op_e;

  typedef struct packed {
    logic    prep;
    logic    mul_start;
    mul_op_e op;
    logic    decide;
    logic    merge;
    logic    emit;
    logic    second;
  } cmd_t;

  typedef struct packed {
    logic open;
    logic gap_ok;
    logic mul_done;
    logic zero_len;
    logic cross_lt;
    logic out_free;
  } status_t;

endpackage

FILE: sv/collinear_segment_merger.sv
// Channel  | dir | signals                          | contents
// s_axis   | in  | tvalid tready tdata tlast        | tdata: start_x, start_y, end_x, end_y
//          |     |                                  | tlast: final_segment
// m_axis   | out | tvalid tready tdata tuser tlast  | tdata: point_x, point_y
//          |     |                                  | tuser: new_polyline, tlast: run_last
// cfg      | in  | cfg_we_i cfg_idx_i cfg_data_i    | 0: join_tolerance, 1: collinear_tolerance
//
// One segment at a time. A segment that cannot join (no open polyline or gap too
// large) skips the products. A join candidate runs up to ten products through one
// shared 16-bit-digit serial multiplier. The output register holds a result under
// backpressure while the next segment is accepted. Reset: no open polyline,
// collinear_tolerance = 66.
module collinear_segment_merger #(
  parameter int COORD_W = csm_pkg::COORD_W_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded
  input  logic [((4*COORD_W+7)/8)*8-1:0]     s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // point_x, point_y from bit 0 up, zero padded
  output logic [((2*COORD_W+7)/8)*8-1:0]     m_axis_tdata,
  // new_polyline
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [csm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [csm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import csm_pkg::*;

  localparam int ODW = ((2 * COORD_W + 7) / 8) * 8;

  cmd_t    cmd;
  status_t status;
  logic    in_fire;

  logic signed [COORD_W-1:0] point_x, point_y;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  csm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  csm_dpath #(
    .COORD_W (COORD_W)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .capture_i      (in_fire),
    .start_x_i      (s_axis_tdata[0*COORD_W +: COORD_W]),
    .start_y_i      (s_axis_tdata[1*COORD_W +: COORD_W]),
    .end_x_i        (s_axis_tdata[2*COORD_W +: COORD_W]),
    .end_y_i        (s_axis_tdata[3*COORD_W +: COORD_W]),
    .final_i        (s_axis_tlast),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .point_x_o      (point_x),
    .point_y_o      (point_y),
    .new_polyline_o (m_axis_tuser),
    .run_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = ODW'({point_y, point_x});

endmodule

FILE: sv/csm_mul.sv
// Digit-serial unsigned multiplier, MSB digit first, one digit per cycle.
// Depends on csm_pkg for the default digit width.
module csm_mul #(
  parameter int AW = 82,
  parameter int BW = 50,
  parameter int DW = csm_pkg::DIGIT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int ND  = (BW + DW - 1) / DW;
  localparam int BPW = ND * DW;
  localparam int PW  = AW + BW;
  localparam int CW  = $clog2(ND + 1);

  logic [AW-1:0]    a_q;
  logic [BPW-1:0]   b_q;
  logic [PW-1:0]    acc_q, acc_d;
  logic [AW+DW-1:0] pp;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;

  always_comb begin
    pp    = a_q * b_q[BPW-1 -: DW];
    acc_d = {acc_q[PW-DW-1:0], {DW{1'b0}}} + PW'(pp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ND);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BPW'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[BPW-DW-1:0], {DW{1'b0}}};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: sv/csm_dpath.sv
// Datapath: config registers, polyline state, differences, product registers,
// shared multiplier and output register. Depends on csm_pkg and csm_mul.
module csm_dpath #(
  parameter int COORD_W = csm_pkg::COORD_W_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [csm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [csm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                capture_i,
  input  logic signed [COORD_W-1:0]           start_x_i,
  input  logic signed [COORD_W-1:0]           start_y_i,
  input  logic signed [COORD_W-1:0]           end_x_i,
  input  logic signed [COORD_W-1:0]           end_y_i,
  input  logic                                final_i,
  input  csm_pkg::cmd_t                       cmd_i,
  output csm_pkg::status_t                    status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COORD_W-1:0]           point_x_o,
  output logic signed [COORD_W-1:0]           point_y_o,
  output logic                                new_polyline_o,
  output logic                                run_last_o
);

  import csm_pkg::*;

  localparam int W   = COORD_W;
  localparam int MW  = W + 1;
  localparam int LW  = 2 * W + 2;
  localparam int TW  = 2 * CT_W;
  localparam int R1W = LW + TW;
  localparam int BW  = (LW > TW) ? LW : TW;
  localparam int PW  = R1W + BW;
  localparam int C2W = 2 * LW;

  function automatic logic [MW-1:0] mag_f(input logic signed [MW-1:0] v);
    mag_f = v[MW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  logic [JT_W-1:0] jt_q;
  logic [CT_W-1:0] ct_q;

  logic signed [W-1:0] prev_x_q, prev_y_q, tail_x_q, tail_y_q;
  logic                open_q;

  logic signed [W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                fin_q;

  logic [MW-1:0] d0x_m_q, d0y_m_q, d1x_m_q, d1y_m_q;
  logic          s0x_q, s0y_q, s1x_q, s1y_q;
  logic          gap_ok_q;

  logic signed [MW-1:0] d0x, d0y, d1x, d1y, gx, gy;
  logic                 gap_ok_d;

  logic [LW-1:0]  t_q, l0_q, l1_q, c_q, prod_lo, c_next;
  logic [C2W-1:0] c2_q;
  logic [TW-1:0]  tol2_q;
  logic [R1W-1:0] r1_q;
  logic [PW-1:0]  rhs_q;

  logic [R1W-1:0] mul_a;
  logic [BW-1:0]  mul_b;
  logic [PW-1:0]  prod;
  logic           mul_done;

  logic                oval_q;
  logic signed [W-1:0] opx_q, opy_q;
  logic                onp_q, olast_q;
  logic                out_free, out_load;

  // ---- differences and endpoint gap
  always_comb begin
    d0x = $signed({tail_x_q[W-1], tail_x_q}) - $signed({prev_x_q[W-1], prev_x_q});
    d0y = $signed({tail_y_q[W-1], tail_y_q}) - $signed({prev_y_q[W-1], prev_y_q});
    d1x = $signed({ex_q[W-1], ex_q}) - $signed({sx_q[W-1], sx_q});
    d1y = $signed({ey_q[W-1], ey_q}) - $signed({sy_q[W-1], sy_q});
    gx  = $signed({tail_x_q[W-1], tail_x_q}) - $signed({sx_q[W-1], sx_q});
    gy  = $signed({tail_y_q[W-1], tail_y_q}) - $signed({sy_q[W-1], sy_q});
    gap_ok_d = (mag_f(gx) <= MW'(jt_q)) && (mag_f(gy) <= MW'(jt_q));
  end

  // ---- multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_D0X2: begin mul_a = R1W'(d0x_m_q); mul_b = BW'(d0x_m_q); end
      OP_D0Y2: begin mul_a = R1W'(d0y_m_q); mul_b = BW'(d0y_m_q); end
      OP_D1X2: begin mul_a = R1W'(d1x_m_q); mul_b = BW'(d1x_m_q); end
      OP_D1Y2: begin mul_a = R1W'(d1y_m_q); mul_b = BW'(d1y_m_q); end
      OP_P:    begin mul_a = R1W'(d0x_m_q); mul_b = BW'(d1y_m_q); end
      OP_Q:    begin mul_a = R1W'(d0y_m_q); mul_b = BW'(d1x_m_q); end
      OP_C2:   begin mul_a = R1W'(c_q);     mul_b = BW'(c_q);     end
      OP_TOL2: begin mul_a = R1W'(ct_q);    mul_b = BW'(ct_q);    end
      OP_R1:   begin mul_a = R1W'(l0_q);    mul_b = BW'(tol2_q);  end
      OP_RHS:  begin mul_a = r1_q;          mul_b = BW'(l1_q);    end
      default: ;
    endcase
  end

  csm_mul #(
    .AW (R1W),
    .BW (BW),
    .DW (DIGIT_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // cross = |p - q| when the two terms carry the same sign, else p + q
  always_comb begin
    prod_lo = prod[LW-1:0];
    if ((s0x_q ^ s1y_q) != (s0y_q ^ s1x_q)) begin
      c_next = t_q + prod_lo;
    end else if (t_q >= prod_lo) begin
      c_next = t_q - prod_lo;
    end else begin
      c_next = prod_lo - t_q;
    end
  end

  // ---- control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jt_q     <= '0;
      ct_q     <= CT_RESET;
      prev_x_q <= '0;
      prev_y_q <= '0;
      tail_x_q <= '0;
      tail_y_q <= '0;
      open_q   <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_JOIN_TOL: jt_q <= cfg_data_i[JT_W-1:0];
          REG_COLL_TOL: ct_q <= cfg_data_i[CT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.decide) begin
        prev_x_q <= cmd_i.merge ? tail_x_q : sx_q;
        prev_y_q <= cmd_i.merge ? tail_y_q : sy_q;
        tail_x_q <= ex_q;
        tail_y_q <= ey_q;
        open_q   <= !fin_q;
      end
      if (out_load) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  // ---- payload registers
  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      sx_q  <= start_x_i;
      sy_q  <= start_y_i;
      ex_q  <= end_x_i;
      ey_q  <= end_y_i;
      fin_q <= final_i;
    end
    if (cmd_i.prep) begin
      d0x_m_q  <= mag_f(d0x);
      d0y_m_q  <= mag_f(d0y);
      d1x_m_q  <= mag_f(d1x);
      d1y_m_q  <= mag_f(d1y);
      s0x_q    <= d0x[MW-1];
      s0y_q    <= d0y[MW-1];
      s1x_q    <= d1x[MW-1];
      s1y_q    <= d1y[MW-1];
      gap_ok_q <= gap_ok_d;
    end
    if (mul_done) begin
      case (cmd_i.op)
        OP_D0X2: t_q    <= prod_lo;
        OP_D0Y2: l0_q   <= t_q + prod_lo;
        OP_D1X2: t_q    <= prod_lo;
        OP_D1Y2: l1_q   <= t_q + prod_lo;
        OP_P:    t_q    <= prod_lo;
        OP_Q:    c_q    <= c_next;
        OP_C2:   c2_q   <= prod[C2W-1:0];
        OP_TOL2: tol2_q <= prod[TW-1:0];
        OP_R1:   r1_q   <= prod[R1W-1:0];
        OP_RHS:  rhs_q  <= prod;
        default: ;
      endcase
    end
    if (out_load) begin
      if (cmd_i.second || cmd_i.merge) begin
        opx_q   <= ex_q;
        opy_q   <= ey_q;
        onp_q   <= 1'b0;
        olast_q <= 1'b1;
      end else begin
        opx_q   <= sx_q;
        opy_q   <= sy_q;
        onp_q   <= 1'b1;
        olast_q <= 1'b0;
      end
    end
  end

  assign out_free = !oval_q || out_ready_i;
  assign out_load = cmd_i.emit && out_free;

  always_comb begin
    status_o.open     = open_q;
    status_o.gap_ok   = gap_ok_q;
    status_o.mul_done = mul_done;
    status_o.zero_len = (l0_q == '0) || (l1_q == '0);
    // cross^2 * 2^32 against tol^2 * |d0|^2 * |d1|^2
    status_o.cross_lt = PW'({c2_q, {TW{1'b0}}}) < rhs_q;
    status_o.out_free = out_free;
  end

  assign out_valid_o    = oval_q;
  assign point_x_o      = opx_q;
  assign point_y_o      = opy_q;
  assign new_polyline_o = onp_q;
  assign run_last_o     = olast_q;

endmodule

FILE: sv/csm_ctrl.sv
// Controller FSM: sequences prep, the product chain, the join decision
// and result emission. Depends on csm_pkg.
module csm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  output logic             in_ready_o,
  input  csm_pkg::status_t status_i,
  output csm_pkg::cmd_t    cmd_o
);

  import csm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EVAL,
    ST_MWAIT,
    ST_ZCHK,
    ST_JUDGE,
    ST_EMIT0,
    ST_EMIT1
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   math_q;
  cmd_t   cmd_q;

  function automatic mul_op_e next_op(input mul_op_e op);
    case (op)
      OP_D0X2: next_op = OP_D0Y2;
      OP_D0Y2: next_op = OP_D1X2;
      OP_D1X2: next_op = OP_D1Y2;
      OP_D1Y2: next_op = OP_P;
      OP_P:    next_op = OP_Q;
      OP_Q:    next_op = OP_C2;
      OP_C2:   next_op = OP_TOL2;
      OP_TOL2: next_op = OP_R1;
      OP_R1:   next_op = OP_RHS;
      default: next_op = OP_RHS;
    endcase
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      math_q  <= 1'b0;
      cmd_q   <= '0;
    end else begin
      cmd_q.prep      <= 1'b0;
      cmd_q.mul_start <= 1'b0;
      cmd_q.decide    <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_fire_i) begin
            ready_q    <= 1'b0;
            cmd_q.prep <= 1'b1;
            state_q    <= ST_PREP;
          end
        end
        ST_PREP: state_q <= ST_EVAL;
        ST_EVAL: begin
          if (status_i.open && status_i.gap_ok) begin
            math_q          <= 1'b1;
            cmd_q.op        <= OP_D0X2;
            cmd_q.mul_start <= 1'b1;
            state_q         <= ST_MWAIT;
          end else begin
            math_q  <= 1'b0;
            state_q <= ST_JUDGE;
          end
        end
        ST_MWAIT: begin
          if (status_i.mul_done) begin
            if (cmd_q.op == OP_RHS) begin
              state_q <= ST_JUDGE;
            end else if (cmd_q.op == OP_D1Y2) begin
              state_q <= ST_ZCHK;
            end else begin
              cmd_q.op        <= next_op(cmd_q.op);
              cmd_q.mul_start <= 1'b1;
            end
          end
        end
        ST_ZCHK: begin
          // a zero-length direction always joins, skip the cross test
          if (status_i.zero_len) begin
            state_q <= ST_JUDGE;
          end else begin
            cmd_q.op        <= OP_P;
            cmd_q.mul_start <= 1'b1;
            state_q         <= ST_MWAIT;
          end
        end
        ST_JUDGE: begin
          cmd_q.decide <= 1'b1;
          cmd_q.merge  <= math_q && (status_i.zero_len || status_i.cross_lt);
          cmd_q.emit   <= 1'b1;
          cmd_q.second <= 1'b0;
          state_q      <= ST_EMIT0;
        end
        ST_EMIT0: begin
          if (status_i.out_free) begin
            if (cmd_q.merge) begin
              cmd_q.emit <= 1'b0;
              ready_q    <= 1'b1;
              state_q    <= ST_IDLE;
            end else begin
              cmd_q.second <= 1'b1;
              state_q      <= ST_EMIT1;
            end
          end
        end
        ST_EMIT1: begin
          if (status_i.out_free) begin
            cmd_q.emit   <= 1'b0;
            cmd_q.second <= 1'b0;
            ready_q      <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = ready_q;
  assign cmd_o      = cmd_q;

endmodule
